/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the palette search and blend block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pncb_pkg.sv */
// ----------------------------------------------------------------------------
// pncb_pkg
// Types, constants and helper functions shared by the palette search and
// blend controller, datapath and top level.
// ----------------------------------------------------------------------------
package pncb_pkg;

   localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;

   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned STRENGTH_W  = 7;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned CHAN_IN_W   = 10;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned CSR_DATA_W  = 9;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned PROD_W      = 16;
   localparam int unsigned MAG_W       = 15;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned QUOT_W      = 9;
   localparam int unsigned SQ_W        = 17;
   localparam int unsigned DIST_W      = 18;

   // Division by 100 as multiplication by 5243 and a shift by 19; exact for
   // magnitudes below 2^15.
   localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
   localparam int unsigned        RECIP_SHIFT = 19;

   localparam logic [STRENGTH_W-1:0] STRENGTH_MIN   = 7'd1;
   localparam logic [STRENGTH_W-1:0] STRENGTH_MAX   = 7'd100;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 7'd100;

   typedef logic [2:0][CHAN_W-1:0] color_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_BLEND = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PALETTE_COUNT  = 1'b0,
      CSR_BLEND_STRENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_A,
      ST_READ_B,
      ST_MIX_MUL,
      ST_MIX_DIV,
      ST_MIX_ADD,
      ST_SEARCH
   } state_type;

   typedef enum logic [1:0] {
      RD_HERE,
      RD_FROM,
      RD_SCAN
   } read_sel_type;

   typedef enum logic {
      TGT_QUERY,
      TGT_MIX
   } target_sel_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_ONE,
      RES_HERE,
      RES_BEST,
      RES_BLEND
   } result_sel_type;

   typedef struct packed {
      logic           capture;
      logic           mem_write;
      read_sel_type   read_sel;
      logic           a_load;
      logic           target_load;
      target_sel_type target_sel;
      logic           search_init;
      logic           search_run;
      logic           result_load;
      result_sel_type result_sel;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       small_palette;
      logic       blend_skip;
      logic       search_done;
   } dp_status_type;

   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

   function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [CHAN_IN_W-1:0] v);
      logic [CHAN_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 10'sd255) begin
         r = '1;
      end else begin
         r = v[CHAN_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/pncb_dp.sv */
// ----------------------------------------------------------------------------
// pncb_dp
// Datapath: configuration registers, palette memory, percentage mix and the
// pipelined squared-distance scan over the palette.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pncb_dp import pncb_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data,
   input  logic [1:0]                  req_opcode,
   input  logic [INDEX_W-1:0]          req_entry_index,
   input  logic [WORD_W-1:0]           req_palette_word,
   input  logic signed [CHAN_IN_W-1:0] req_red,
   input  logic signed [CHAN_IN_W-1:0] req_green,
   input  logic signed [CHAN_IN_W-1:0] req_blue,
   input  logic [INDEX_W-1:0]          req_current_index,
   input  logic [INDEX_W-1:0]          req_pulled_index,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status,
   output logic [INDEX_W-1:0]          rsp_result_index,
   output logic                        rsp_changed
);

   localparam int unsigned ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [COUNT_W-1:0] ENTRIES_LIMIT = COUNT_W'(PALETTE_ENTRIES);

   logic [COUNT_W-1:0]          count_ff;
   logic [STRENGTH_W-1:0]       strength_ff;
   logic [COUNT_W-1:0]          live_count;
   logic [STRENGTH_W-1:0]       strength_eff;

   opcode_type                  op_ff;
   logic [INDEX_W-1:0]          entry_ff;
   logic [WORD_W-1:0]           word_ff;
   logic signed [CHAN_IN_W-1:0] red_ff;
   logic signed [CHAN_IN_W-1:0] green_ff;
   logic signed [CHAN_IN_W-1:0] blue_ff;
   logic [INDEX_W-1:0]          here_ff;
   logic [INDEX_W-1:0]          from_ff;
   logic                        here_in_range;

   color_type                   palette_mem [PALETTE_ENTRIES];
   color_type                   rdata_ff;
   color_type                   wcolor;
   logic                        mem_we;
   logic [COUNT_W-1:0]          raddr_wide;
   logic [ADDR_W-1:0]           raddr;

   color_type                   a_ff;
   logic signed [PROD_W-1:0]    p_ff [3];
   logic signed [PROD_W-1:0]    p_in [3];
   logic signed [CHAN_IN_W-1:0] q_ff [3];
   logic signed [CHAN_IN_W-1:0] q_in [3];
   color_type                   mix_color;
   color_type                   query_color;
   color_type                   target_ff;

   logic [COUNT_W-1:0]          scan_addr_ff;
   logic                        issue;
   logic                        v1_ff;
   logic                        v2_ff;
   logic                        have_ff;
   logic [INDEX_W-1:0]          idx1_ff;
   logic [INDEX_W-1:0]          idx2_ff;
   logic [SQ_W-1:0]             sq_ff [3];
   logic [SQ_W-1:0]             sq_in [3];
   logic [DIST_W-1:0]           sq_total;
   logic [DIST_W-1:0]           best_dist_ff;
   logic [INDEX_W-1:0]          best_idx_ff;

   logic [INDEX_W-1:0]          result_ff;
   logic                        changed_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         strength_ff <= STRENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PALETTE_COUNT:  count_ff    <= csr_write_data;
            CSR_BLEND_STRENGTH: strength_ff <= csr_write_data[STRENGTH_W-1:0];
         endcase
      end
   end

   always_comb begin
      live_count = (count_ff < ENTRIES_LIMIT) ? count_ff : ENTRIES_LIMIT;
      priority if (strength_ff < STRENGTH_MIN) begin
         strength_eff = STRENGTH_MIN;
      end else if (strength_ff > STRENGTH_MAX) begin
         strength_eff = STRENGTH_MAX;
      end else begin
         strength_eff = strength_ff;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= opcode_type'(req_opcode);
         entry_ff <= req_entry_index;
         word_ff  <= req_palette_word;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         here_ff  <= req_current_index;
         from_ff  <= req_pulled_index;
      end
   end

   assign here_in_range = {1'b0, here_ff} < live_count;

   always_comb begin
      status.opcode        = op_ff;
      status.small_palette = live_count <= COUNT_W'(1);
      status.blend_skip    = (live_count <= COUNT_W'(1)) || (from_ff == '0) ||
                             ({1'b0, from_ff} >= live_count) || (here_ff == '0);
      status.search_done   = cmd.search_run && !issue && !v1_ff && !v2_ff;
   end

   // Palette memory, one write and one registered read per cycle.
   assign wcolor = {widen5(word_ff[14:10]), widen5(word_ff[9:5]), widen5(word_ff[4:0])};
   assign mem_we = cmd.mem_write && ({1'b0, entry_ff} < ENTRIES_LIMIT);

   always_comb begin
      unique case (cmd.read_sel)
         RD_HERE: raddr_wide = here_in_range ? {1'b0, here_ff} : '0;
         RD_FROM: raddr_wide = {1'b0, from_ff};
         RD_SCAN: raddr_wide = scan_addr_ff;
         default: raddr_wide = scan_addr_ff;
      endcase
      raddr = raddr_wide[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[entry_ff[ADDR_W-1:0]] <= wcolor;
      end
      rdata_ff <= palette_mem[raddr];
   end

   // Mix: multiply, divide by 100, add; one register after each step.
   always_comb begin
      logic signed [INDEX_W:0]    diff;
      logic signed [PROD_W:0]     prod;
      logic signed [PROD_W-1:0]   mag_s;
      logic [MAG_W-1:0]           mag;
      logic [MAG_W+RECIP_W-1:0]   recip;
      logic [QUOT_W-1:0]          quot;
      logic signed [CHAN_IN_W-1:0] sum;
      for (int c = 0; c < 3; c++) begin
         diff    = $signed({1'b0, rdata_ff[c]}) - $signed({1'b0, a_ff[c]});
         prod    = diff * $signed({1'b0, strength_eff});
         p_in[c] = prod[PROD_W-1:0];

         mag_s   = p_ff[c][PROD_W-1] ? -p_ff[c] : p_ff[c];
         mag     = mag_s[MAG_W-1:0];
         recip   = mag * RECIP_100;
         quot    = recip[RECIP_SHIFT +: QUOT_W];
         q_in[c] = p_ff[c][PROD_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

         sum          = $signed({2'b00, a_ff[c]}) + q_ff[c];
         mix_color[c] = sum[CHAN_W-1:0];
      end
   end

   assign query_color = {clamp_channel(red_ff), clamp_channel(green_ff), clamp_channel(blue_ff)};

   always_ff @(posedge clock) begin
      if (cmd.a_load) begin
         a_ff <= rdata_ff;
      end
      for (int c = 0; c < 3; c++) begin
         p_ff[c] <= p_in[c];
         q_ff[c] <= q_in[c];
      end
      if (cmd.target_load) begin
         target_ff <= (cmd.target_sel == TGT_MIX) ? mix_color : query_color;
      end
   end

   // Scan: address issue, memory read, squares, sum and compare.
   assign issue = cmd.search_run && (scan_addr_ff < live_count);

   always_comb begin
      logic signed [INDEX_W:0]  dch;
      logic signed [SQ_W:0]     sq;
      for (int c = 0; c < 3; c++) begin
         dch      = $signed({1'b0, target_ff[c]}) - $signed({1'b0, rdata_ff[c]});
         sq       = dch * dch;
         sq_in[c] = sq[SQ_W-1:0];
      end
      sq_total = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else if (cmd.search_init) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (v2_ff) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         scan_addr_ff <= COUNT_W'(1);
      end else if (issue) begin
         scan_addr_ff <= scan_addr_ff + COUNT_W'(1);
      end
      idx1_ff <= scan_addr_ff[INDEX_W-1:0];
      idx2_ff <= idx1_ff;
      for (int c = 0; c < 3; c++) begin
         sq_ff[c] <= sq_in[c];
      end
      if (v2_ff && (!have_ff || (sq_total < best_dist_ff))) begin
         best_dist_ff <= sq_total;
         best_idx_ff  <= idx2_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         unique case (cmd.result_sel)
            RES_ZERO: begin
               result_ff  <= '0;
               changed_ff <= 1'b0;
            end
            RES_ONE: begin
               result_ff  <= INDEX_W'(1);
               changed_ff <= 1'b0;
            end
            RES_HERE: begin
               result_ff  <= here_ff;
               changed_ff <= 1'b0;
            end
            RES_BEST: begin
               result_ff  <= best_idx_ff;
               changed_ff <= 1'b0;
            end
            RES_BLEND: begin
               result_ff  <= best_idx_ff;
               changed_ff <= best_idx_ff != here_ff;
            end
            default: begin
               result_ff  <= '0;
               changed_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_result_index = result_ff;
   assign rsp_changed      = changed_ff;

   `ASSERT_IMPLIES(a_first_compare_is_one, clock, reset, v2_ff && !have_ff, idx2_ff == INDEX_W'(1), "first compared entry is not index one")
   `ASSERT_IMPLIES(a_compare_never_zero, clock, reset, v2_ff, idx2_ff != '0, "transparent entry entered the scan")

endmodule

/* rtl/pncb_ctrl.sv */
// ----------------------------------------------------------------------------
// pncb_ctrl
// Controller: sequences load, query and blend operations over the datapath
// and drives the busy flag and the result strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pncb_ctrl import pncb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_strobe,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.result_load;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.opcode)
               OP_QUERY: state_in = status.small_palette ? ST_IDLE : ST_SEARCH;
               OP_BLEND: state_in = status.blend_skip ? ST_IDLE : ST_READ_A;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_READ_A:  state_in = ST_READ_B;
         ST_READ_B:  state_in = ST_MIX_MUL;
         ST_MIX_MUL: state_in = ST_MIX_DIV;
         ST_MIX_DIV: state_in = ST_MIX_ADD;
         ST_MIX_ADD: state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.read_sel   = RD_SCAN;
      cmd.target_sel = TGT_QUERY;
      cmd.result_sel = RES_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_DECODE: begin
            unique case (status.opcode)
               OP_LOAD: begin
                  cmd.mem_write   = 1'b1;
                  cmd.result_load = 1'b1;
               end
               OP_QUERY: begin
                  if (status.small_palette) begin
                     cmd.result_sel  = RES_ONE;
                     cmd.result_load = 1'b1;
                  end else begin
                     cmd.target_load = 1'b1;
                     cmd.search_init = 1'b1;
                  end
               end
               OP_BLEND: begin
                  if (status.blend_skip) begin
                     cmd.result_sel  = RES_HERE;
                     cmd.result_load = 1'b1;
                  end
               end
               default: begin
                  cmd.result_load = 1'b1;
               end
            endcase
         end
         ST_READ_A: begin
            cmd.read_sel = RD_HERE;
         end
         ST_READ_B: begin
            cmd.read_sel = RD_FROM;
            cmd.a_load   = 1'b1;
         end
         ST_MIX_MUL: begin
         end
         ST_MIX_DIV: begin
         end
         ST_MIX_ADD: begin
            cmd.target_sel  = TGT_MIX;
            cmd.target_load = 1'b1;
            cmd.search_init = 1'b1;
         end
         ST_SEARCH: begin
            cmd.search_run = 1'b1;
            if (status.search_done) begin
               cmd.result_load = 1'b1;
               cmd.result_sel  = (status.opcode == OP_BLEND) ? RES_BLEND : RES_BEST;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;

   `ASSERT_IMPLIES(a_strobe_when_idle, clock, reset, rsp_strobe, !busy, "result beat shown while busy")
   `ASSERT_IMPLIES(a_strobe_after_work, clock, reset, rsp_strobe, $past(busy), "result beat without preceding work")
   `ASSERT_NEXT(a_accept_decodes, clock, reset, start && !busy, state_ff == ST_DECODE, "accepted request not decoded")

endmodule

/* rtl/palette_nearest_color_blend.sv */
// ----------------------------------------------------------------------------
// palette_nearest_color_blend
// Palette of RGB555 colors expanded to 8 bits per channel, with nearest color
// search and percentage blending between two palette entries.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an operation on the req_ ports; it is taken when busy is
//   low. Opcode 0 loads an entry, 1 searches the nearest opaque entry to a
//   color, 2 blends two entries and requantizes the mix.
//   Each request produces one result beat: rsp_strobe is high for one cycle
//   with rsp_result_index and rsp_changed. The receiver cannot stall it.
//   With n the palette count in effect: loads, skipped blends and palettes of
//   one entry or less give the beat from the decode state; a query then scans
//   the palette; a blend reads both entries and mixes them first. The scan
//   reads one palette entry per cycle through the single read port of the
//   palette memory, so n sets the time per item.
//   A new request may be taken in the cycle the previous beat is shown.
//   The csr_ port writes the palette count (index 0) and the blend strength
//   (index 1); write it only while no request is in flight.
//   Reset clears the count to 0 and the strength to 100 and returns to idle;
//   palette contents are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module palette_nearest_color_blend import pncb_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic [INDEX_W-1:0]          req_entry_index,
   input  logic [WORD_W-1:0]           req_palette_word,
   input  logic signed [CHAN_IN_W-1:0] req_red,
   input  logic signed [CHAN_IN_W-1:0] req_green,
   input  logic signed [CHAN_IN_W-1:0] req_blue,
   input  logic [INDEX_W-1:0]          req_current_index,
   input  logic [INDEX_W-1:0]          req_pulled_index,
   output logic                        rsp_strobe,
   output logic [INDEX_W-1:0]          rsp_result_index,
   output logic                        rsp_changed,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   pncb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   pncb_dp #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_palette_word  (req_palette_word),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_current_index (req_current_index),
      .req_pulled_index  (req_pulled_index),
      .cmd               (cmd),
      .status            (status),
      .rsp_result_index  (rsp_result_index),
      .rsp_changed       (rsp_changed)
   );

endmodule

/* verif/palette_nearest_color_blend_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_nearest_color_blend_tb
// Drives loads, nearest color queries, blends and the unused opcode into the
// palette block. A scoreboard keeps its own copy of the expanded palette and
// the two registers and checks every result beat against the predicted index
// and changed flag. A short directed part covers tiny palettes, ties, skipped
// blends, an out-of-range current index and truncating mixes. The palette is
// then filled, and random phases follow, each with its own count and strength.
// ----------------------------------------------------------------------------
module palette_nearest_color_blend_tb;
   import pncb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 45;

   typedef struct packed {
      opcode_type                  opcode;
      logic [INDEX_W-1:0]          entry_index;
      logic [WORD_W-1:0]           palette_word;
      logic signed [CHAN_IN_W-1:0] red;
      logic signed [CHAN_IN_W-1:0] green;
      logic signed [CHAN_IN_W-1:0] blue;
      logic [INDEX_W-1:0]          current_index;
      logic [INDEX_W-1:0]          pulled_index;
   } request_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               changed;
   } outcome_type;

   class palette_mirror_type;
      int                  red_of[PALETTE_ENTRIES_DEFAULT];
      int                  green_of[PALETTE_ENTRIES_DEFAULT];
      int                  blue_of[PALETTE_ENTRIES_DEFAULT];
      logic [COUNT_W-1:0]  count_reg;
      logic [STRENGTH_W-1:0] strength_reg;
      outcome_type         awaited_results[$];
      int                  mismatches;

      function new();
         count_reg = '0;
         strength_reg = STRENGTH_RESET;
         mismatches = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PALETTE_COUNT) begin
            count_reg = data[COUNT_W-1:0];
         end else begin
            strength_reg = data[STRENGTH_W-1:0];
         end
      endfunction

      function int live_entries();
         return (count_reg > PALETTE_ENTRIES_DEFAULT) ? PALETTE_ENTRIES_DEFAULT : count_reg;
      endfunction

      function int clamp_byte(int v);
         return (v < 0) ? 0 : ((v > 255) ? 255 : v);
      endfunction

      function int nearest_entry(int r, int g, int b);
         int live;
         int best;
         int best_dist;
         int sq_total;
         live = live_entries();
         best = 1;
         best_dist = 0;
         if (live <= 1) begin
            return 1;
         end
         r = clamp_byte(r);
         g = clamp_byte(g);
         b = clamp_byte(b);
         for (int i = 1; i < live; i++) begin
            sq_total = (r - red_of[i]) * (r - red_of[i]) + (g - green_of[i]) * (g - green_of[i])
                     + (b - blue_of[i]) * (b - blue_of[i]);
            if (i == 1 || sq_total < best_dist) begin
               best_dist = sq_total;
               best = i;
            end
         end
         return best;
      endfunction

      function int blend_channel(int a, int b, int s);
         return a + ((b - a) * s) / 100;
      endfunction

      function void note_request(request_type req);
         outcome_type outcome;
         int       live;
         int       here;
         int       from;
         int       s;
         outcome = '0;
         live = live_entries();
         here = req.current_index;
         from = req.pulled_index;
         case (req.opcode)
            OP_LOAD: begin
               red_of[req.entry_index]   = {req.palette_word[14:10], req.palette_word[14:12]};
               green_of[req.entry_index] = {req.palette_word[9:5], req.palette_word[9:7]};
               blue_of[req.entry_index]  = {req.palette_word[4:0], req.palette_word[4:2]};
            end
            OP_QUERY: begin
               outcome.index = INDEX_W'(nearest_entry($signed(req.red), $signed(req.green),
                                                      $signed(req.blue)));
            end
            OP_BLEND: begin
               outcome.index = req.current_index;
               if (live > 1 && from != 0 && from < live && here != 0) begin
                  s = strength_reg;
                  if (s < STRENGTH_MIN) s = STRENGTH_MIN;
                  if (s > STRENGTH_MAX) s = STRENGTH_MAX;
                  if (here >= live) here = 0;
                  outcome.index = INDEX_W'(nearest_entry(
                     blend_channel(red_of[here], red_of[from], s),
                     blend_channel(green_of[here], green_of[from], s),
                     blend_channel(blue_of[here], blue_of[from], s)));
                  outcome.changed = (outcome.index != req.current_index);
               end
            end
            default: begin
            end
         endcase
         awaited_results = {awaited_results, outcome};
      endfunction

      function void check_beat(logic [INDEX_W-1:0] index, logic changed);
         outcome_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected beat, index %0d changed %0d", $time, index, changed);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         if (index !== want.index) begin
            $display("%0t: result_index expected %0d, actual %0d", $time, want.index, index);
            mismatches++;
         end
         if (changed !== want.changed) begin
            $display("%0t: changed expected %0d, actual %0d", $time, want.changed, changed);
            mismatches++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_opcode;
   logic [INDEX_W-1:0]          req_entry_index;
   logic [WORD_W-1:0]           req_palette_word;
   logic signed [CHAN_IN_W-1:0] req_red;
   logic signed [CHAN_IN_W-1:0] req_green;
   logic signed [CHAN_IN_W-1:0] req_blue;
   logic [INDEX_W-1:0]          req_current_index;
   logic [INDEX_W-1:0]          req_pulled_index;
   logic                        rsp_strobe;
   logic [INDEX_W-1:0]          rsp_result_index;
   logic                        rsp_changed;
   logic                        csr_write_enable;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_write_data;

   palette_mirror_type mirror = new();
   int                 idle_cycles = 0;

   palette_nearest_color_blend dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_palette_word  (req_palette_word),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_current_index (req_current_index),
      .req_pulled_index  (req_pulled_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_index  (rsp_result_index),
      .rsp_changed       (rsp_changed),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         mirror.check_beat(rsp_result_index, rsp_changed);
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [WORD_W-1:0] random_word();
      logic [WORD_W-1:0] swatches[6] = '{16'h0000, 16'h7FFF, 16'hFFFF, 16'h4210, 16'h8000,
                                         16'h03E0};
      if ($urandom_range(0, 3) == 0) begin
         return swatches[$urandom_range(0, 5)];
      end
      return WORD_W'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic signed [CHAN_IN_W-1:0] random_channel();
      int v;
      if ($urandom_range(0, 9) < 7) begin
         v = $urandom_range(0, 295) - 20;
      end else begin
         v = $urandom_range(0, 1023);
      end
      return v[CHAN_IN_W-1:0];
   endfunction

   function automatic logic [INDEX_W-1:0] random_slot(int live);
      if (live > 1 && $urandom_range(0, 9) < 8) begin
         return INDEX_W'($urandom_range(1, live - 1));
      end
      return INDEX_W'($urandom_range(0, 255));
   endfunction

   function automatic request_type random_request(int live);
      request_type req;
      int       pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         req.opcode = OP_LOAD;
      end else if (pick < 11) begin
         req.opcode = OP_QUERY;
      end else if (pick < 19) begin
         req.opcode = OP_BLEND;
      end else begin
         req.opcode = OP_NONE;
      end
      req.entry_index = INDEX_W'($urandom_range(0, 255));
      req.palette_word = random_word();
      req.red = random_channel();
      req.green = random_channel();
      req.blue = random_channel();
      req.current_index = random_slot(live);
      req.pulled_index = random_slot(live);
      return req;
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input request_type req);
      @(negedge clock);
      start = 1'b1;
      req_opcode = req.opcode;
      req_entry_index = req.entry_index;
      req_palette_word = req.palette_word;
      req_red = req.red;
      req_green = req.green;
      req_blue = req.blue;
      req_current_index = req.current_index;
      req_pulled_index = req.pulled_index;
      do @(posedge clock); while (busy);
      mirror.note_request(req);
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (mirror.awaited_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      mirror.write_register(idx, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic load_entry(input int slot, input logic [WORD_W-1:0] word);
      request_type req;
      req = random_request(0);
      req.opcode = OP_LOAD;
      req.entry_index = INDEX_W'(slot);
      req.palette_word = word;
      send_request(req);
   endtask

   task automatic query_color(input int r, input int g, input int b);
      request_type req;
      req = random_request(0);
      req.opcode = OP_QUERY;
      req.red = CHAN_IN_W'(r);
      req.green = CHAN_IN_W'(g);
      req.blue = CHAN_IN_W'(b);
      send_request(req);
   endtask

   task automatic blend_pair(input int here, input int from);
      request_type req;
      req = random_request(0);
      req.opcode = OP_BLEND;
      req.current_index = INDEX_W'(here);
      req.pulled_index = INDEX_W'(from);
      send_request(req);
   endtask

   initial begin
      int unsigned phase_counts[12] = '{256, 9, 2, 17, 511, 0, 33, 5, 1, 257, 12, 64};
      int unsigned phase_strengths[12] = '{100, 0, 1, 127, 50, 99, 101, 100, 37, 1, 73, 100};
      request_type req;
      bit          steady;

      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_LOAD;
      req_entry_index = '0;
      req_palette_word = '0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      req_current_index = '0;
      req_pulled_index = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PALETTE_COUNT;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // With an empty palette nothing is read.
      query_color(-512, 511, 0);
      blend_pair(1, 2);
      req = random_request(0);
      req.opcode = OP_NONE;
      send_request(req);
      load_entry(0, 16'h0000);
      load_entry(1, 16'hFFFF);
      load_entry(2, 16'h7FFF);
      load_entry(255, 16'h8000);
      load_entry(3, 16'h4210);
      write_register(CSR_PALETTE_COUNT, 9'd1);
      query_color(255, 255, 255);
      blend_pair(1, 1);
      write_register(CSR_PALETTE_COUNT, 9'd4);
      query_color(511, 511, 511);
      query_color(-1, -1, -1);
      query_color(256, 0, 255);
      query_color(132, 132, 132);
      blend_pair(0, 2);
      blend_pair(3, 0);
      blend_pair(3, 4);
      blend_pair(200, 1);
      blend_pair(3, 1);
      write_register(CSR_BLEND_STRENGTH, 9'd1);
      blend_pair(3, 1);
      blend_pair(200, 3);
      write_register(CSR_BLEND_STRENGTH, 9'd50);
      blend_pair(1, 3);

      // Every entry is written before any random search can read it.
      for (int i = 0; i < PALETTE_ENTRIES_DEFAULT; i++) begin
         load_entry(i, random_word());
         pause_sender(random_gap());
      end

      for (int p = 0; p < 12; p++) begin
         steady = (p % 4 == 1);
         write_register(CSR_PALETTE_COUNT, CSR_DATA_W'(phase_counts[p]));
         write_register(CSR_BLEND_STRENGTH,
                        CSR_DATA_W'(($urandom_range(0, 3) << 7) | phase_strengths[p]));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_request(mirror.live_entries()));
            if (!steady) begin
               pause_sender(random_gap());
            end
            if ($urandom_range(0, 39) == 0) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
